/* rtl/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;

    // Lead byte limits and special lead bytes
    localparam logic [7:0] LEAD_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;
    localparam logic [7:0] LEAD_SURR  = 8'hED;
    localparam logic [7:0] LEAD_TOP   = 8'hF4;

    // Second byte thresholds
    localparam logic [7:0] SEC_E0_MIN  = 8'hA0;
    localparam logic [7:0] SEC_ED_MIN  = 8'hA0;
    localparam logic [7:0] SEC_F0_MIN  = 8'h90;
    localparam logic [7:0] SEC_F4_MAX  = 8'h8F;

    // Continuation byte tag, top two bits
    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADLEAD  = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BADCONT  = 3'd3,
        ST_SURR     = 3'd4,
        ST_OVERLONG = 3'd5,
        ST_RANGE    = 3'd6
    } status_t;

    // Decoder state between bytes; all zero when idle
    typedef struct packed {
        logic [7:0]      lead;
        logic [1:0]      awaited;
        logic [CP_W-1:0] partial;
        status_t         held_fault;
    } dec_state_t;

    // One result, qualified by emit
    typedef struct packed {
        logic               emit;
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        status_t            status;
    } dec_result_t;

    localparam dec_state_t STATE_IDLE = '{
        lead:       8'd0,
        awaited:    2'd0,
        partial:    '0,
        held_fault: ST_OK
    };

endpackage

/* rtl/u8sd_step.sv */
// ----------------------------------------------------------------------------
// u8sd_step
// Next-state and result logic for one input byte of the UTF-8 decoder.
// ----------------------------------------------------------------------------
module u8sd_step
(
    input  u8sd_pkg::dec_state_t  cur,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_buffer,
    output u8sd_pkg::dec_state_t  nxt,
    output u8sd_pkg::dec_result_t res
);
    import u8sd_pkg::*;

    logic [2:0]      seq_len;
    logic            is_second;
    status_t         fault;
    logic [CP_W-1:0] part;

    // Sequence length implied by the stored lead byte
    always_comb
    begin
        if (cur.lead < LEAD_3BYTE)
        begin
            seq_len = 3'd2;
        end
        else if (cur.lead < LEAD_4BYTE)
        begin
            seq_len = 3'd3;
        end
        else
        begin
            seq_len = 3'd4;
        end
    end

    assign is_second = (({1'b0, cur.awaited} + 3'd1) == seq_len);
    assign part      = {cur.partial[CP_W-7:0], data_byte[5:0]};

    // Overlong, surrogate and range faults seen on the second byte, held until the sequence ends
    always_comb
    begin
        fault = cur.held_fault;
        if (is_second)
        begin
            priority if (cur.lead == LEAD_3BYTE && data_byte < SEC_E0_MIN)
                fault = ST_OVERLONG;
            else if (cur.lead == LEAD_SURR && data_byte >= SEC_ED_MIN)
                fault = ST_SURR;
            else if (cur.lead == LEAD_4BYTE && data_byte < SEC_F0_MIN)
                fault = ST_OVERLONG;
            else if (cur.lead == LEAD_TOP && data_byte > SEC_F4_MAX)
                fault = ST_RANGE;
            else
                fault = cur.held_fault;
        end
    end

    always_comb
    begin
        nxt = cur;
        res = '{emit: 1'b0, code_point: '0, byte_count: '0, status: ST_OK};
        if (cur.awaited == 2'd0)
        begin
            if (!data_byte[7])
            begin
                res.emit       = 1'b1;
                res.code_point = {{(CP_W-8){1'b0}}, data_byte};
                res.byte_count = 3'd1;
            end
            else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX)
            begin
                res.emit   = 1'b1;
                res.status = ST_BADLEAD;
            end
            else if (end_of_buffer)
            begin
                res.emit   = 1'b1;
                res.status = ST_TRUNC;
            end
            else
            begin
                nxt.lead       = data_byte;
                nxt.held_fault = ST_OK;
                if (data_byte < LEAD_3BYTE)
                begin
                    nxt.awaited = 2'd1;
                    nxt.partial = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                end
                else if (data_byte < LEAD_4BYTE)
                begin
                    nxt.awaited = 2'd2;
                    nxt.partial = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                end
                else
                begin
                    nxt.awaited = 2'd3;
                    nxt.partial = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                end
            end
        end
        else if (end_of_buffer && cur.awaited > 2'd1)
        begin
            // truncation wins over the continuation check
            nxt        = STATE_IDLE;
            res.emit   = 1'b1;
            res.status = ST_TRUNC;
        end
        else if (data_byte[7:6] != CONT_TAG)
        begin
            nxt        = STATE_IDLE;
            res.emit   = 1'b1;
            res.status = ST_BADCONT;
        end
        else if (cur.awaited == 2'd1)
        begin
            nxt      = STATE_IDLE;
            res.emit = 1'b1;
            if (fault != ST_OK)
            begin
                res.status = fault;
            end
            else
            begin
                res.code_point = part;
                res.byte_count = seq_len;
            end
        end
        else
        begin
            nxt.awaited    = cur.awaited - 2'd1;
            nxt.partial    = part;
            nxt.held_fault = fault;
        end
    end

endmodule

/* rtl/utf8_stream_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Validating UTF-8 decoder, one byte per request, one result per character.
//
// Usage:
//   Input channel (in_valid/in_ready) carries data_byte and end_of_buffer,
//   one byte of the stream per request. end_of_buffer marks the last byte of
//   a buffer; a sequence still open at that byte is reported as truncated.
//   Output channel (out_valid/out_ready) carries code_point, byte_count and
//   status for each completed or failed character. Bytes that only extend a
//   sequence produce no result.
//   Throughput: one byte per cycle, sustained while out_ready stays high.
//   Latency: a result is valid the cycle after the byte that caused it.
//   The decoder state and the result register update in the same cycle,
//   fed by one pass of the step logic.
//   Stall: the result register holds while out_ready is low; in_ready drops
//   only when that register is full and not being drained this cycle, so a
//   new byte enters in the same cycle the pending result leaves.
//   Reset: rst_n clears the decoder to idle (no sequence open) and empties
//   the result register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_buffer,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8sd_pkg::CP_W-1:0]     code_point,
    output logic [u8sd_pkg::COUNT_W-1:0]  byte_count,
    output logic [2:0]                    status
);
    import u8sd_pkg::*;

    dec_state_t         state_reg;
    dec_state_t         state_next;
    dec_state_t         step_state;
    dec_result_t        step_res;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CP_W-1:0]    cp_reg;
    logic [CP_W-1:0]    cp_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    status_t            status_reg;
    status_t            status_next;

    logic               in_fire;

    // Accept while the result slot is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    u8sd_step u_step
    (
        .cur           (state_reg),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .nxt           (step_state),
        .res           (step_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            state_next = step_state;
            if (step_res.emit)
            begin
                out_valid_next = 1'b1;
                cp_next        = step_res.code_point;
                count_next     = step_res.byte_count;
                status_next    = step_res.status;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        cp_reg     <= cp_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign byte_count = count_reg;
    assign status     = status_reg;

    // Error results carry no character
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (cp_reg == '0 && count_reg == '0))
        else $error("error result with nonzero code point or count");

    // Good results are 1 to 4 bytes long
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OK) |->
        (count_reg != 3'd0 && count_reg <= 3'd4))
        else $error("good result with bad byte count");

    // A held fault only exists inside an open sequence
    a_fault_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.held_fault != ST_OK) |-> (state_reg.awaited != 2'd0))
        else $error("held fault while idle");

    // Idle state is fully cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.awaited == 2'd0) |-> (state_reg.lead == 8'd0 && state_reg.partial == '0))
        else $error("idle state not cleared");

    // A stalled full result slot blocks new bytes
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("byte accepted over a pending result");

endmodule
